// ----- rtl/ipq_pkg.sv -----
// shared types and codes for the indexed priority task queue
package ipq_pkg;

  localparam int MODE_W = 2;
  localparam int TID_W  = 16;
  localparam int UID_W  = 16;
  localparam int PRI_W  = 32;
  localparam int ST_W   = 2;

  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHG  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REM  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EXEC = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

  // running search results handed from cell to cell
  typedef struct packed {
    logic             found;
    logic             free_ok;
    logic             best_ok;
    logic [PRI_W-1:0] best_pri;
    logic [TID_W-1:0] best_tid;
    logic [UID_W-1:0] best_owner;
  } tok_t;

  // update broadcast to all cells, applied by the addressed one
  typedef struct packed {
    logic             en;
    logic             clr;
    logic             keyw;
    logic [TID_W-1:0] tid;
    logic [UID_W-1:0] owner;
    logic [PRI_W-1:0] pri;
  } wr_t;

endpackage

// ----- rtl/ipq_cell.sv -----
// one table slot that folds its entry into the search token and passes it on
module ipq_cell import ipq_pkg::*; #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [TID_W-1:0] cmd_tid,
  input  logic             go_in,
  input  tok_t             tok_in,
  input  logic [IW-1:0]    found_idx_in,
  input  logic [IW-1:0]    free_idx_in,
  input  logic [IW-1:0]    best_idx_in,
  output logic             go_out,
  output tok_t             tok_out,
  output logic [IW-1:0]    found_idx_out,
  output logic [IW-1:0]    free_idx_out,
  output logic [IW-1:0]    best_idx_out,
  input  wr_t              wr,
  input  logic [IW-1:0]    wr_idx
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic             valid;
  logic [TID_W-1:0] tid;
  logic [UID_W-1:0] owner;
  logic [PRI_W-1:0] pri;

  tok_t          tok_next;
  logic [IW-1:0] found_idx_next;
  logic [IW-1:0] free_idx_next;
  logic [IW-1:0] best_idx_next;
  logic          hit;
  logic          beats;
  logic          sel;

  assign hit   = valid && (tid == cmd_tid);
  assign beats = !tok_in.best_ok || ({pri, tid} > {tok_in.best_pri, tok_in.best_tid});
  assign sel   = wr.en && (wr_idx == MY_IDX);

  always_comb begin
    tok_next       = tok_in;
    found_idx_next = found_idx_in;
    free_idx_next  = free_idx_in;
    best_idx_next  = best_idx_in;
    if (hit && !tok_in.found) begin
      tok_next.found = 1'b1;
      found_idx_next = MY_IDX;
    end
    // lowest free slot wins since the token starts at slot zero
    if (!valid && !tok_in.free_ok) begin
      tok_next.free_ok = 1'b1;
      free_idx_next    = MY_IDX;
    end
    if (valid && beats) begin
      tok_next.best_ok    = 1'b1;
      tok_next.best_pri   = pri;
      tok_next.best_tid   = tid;
      tok_next.best_owner = owner;
      best_idx_next       = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      go_out <= 1'b0;
      valid  <= 1'b0;
    end else begin
      go_out <= go_in;
      if (sel) begin
        valid <= !wr.clr;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out       <= tok_next;
    found_idx_out <= found_idx_next;
    free_idx_out  <= free_idx_next;
    best_idx_out  <= best_idx_next;
    if (sel && !wr.clr) begin
      pri <= wr.pri;
      if (wr.keyw) begin
        tid   <= wr.tid;
        owner <= wr.owner;
      end
    end
  end

endmodule

// ----- rtl/indexed_max_priority_task_queue_top.sv -----
// indexed max-priority task table: command control around a chain of slot cells
// a command is registered, its token crosses every slot cell in turn, then the result is registered with done
// busy stays high meanwhile, so no new command is taken until the search is through
// the search token walks the slot chain one cell per cycle
// reset empties the table at once through the slot valid bits, no clearing pass
// the receiver cannot stall: each result is shown for one cycle with done high
module indexed_max_priority_task_queue_top import ipq_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] mode,
  input  logic [TID_W-1:0]  task_id,
  input  logic [UID_W-1:0]  user_id,
  input  logic [PRI_W-1:0]  priority_req,
  output logic              done,
  output logic [UID_W-1:0]  owner,
  output logic [ST_W-1:0]   status
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_RUN  = 1'b1;

  logic [0:0]        state;
  logic [0:0]        state_next;
  logic              inject;
  logic [MODE_W-1:0] cmd_mode;
  logic [TID_W-1:0]  cmd_tid;
  logic [UID_W-1:0]  cmd_uid;
  logic [PRI_W-1:0]  cmd_pri;

  logic          go_c        [SLOTS+1];
  tok_t          tok_c       [SLOTS+1];
  logic [IW-1:0] found_idx_c [SLOTS+1];
  logic [IW-1:0] free_idx_c  [SLOTS+1];
  logic [IW-1:0] best_idx_c  [SLOTS+1];

  wr_t              wr;
  logic [IW-1:0]    wr_idx;
  logic [ST_W-1:0]  res_status;
  logic [UID_W-1:0] res_owner;
  logic             accept;
  logic             finish;
  tok_t             fin;

  assign busy   = (state == S_RUN);
  assign accept = start && !busy;
  assign finish = go_c[SLOTS];
  assign fin    = tok_c[SLOTS];

  assign go_c[0]        = inject;
  assign tok_c[0]       = '0;
  assign found_idx_c[0] = '0;
  assign free_idx_c[0]  = '0;
  assign best_idx_c[0]  = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ipq_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd_tid      (cmd_tid),
      .go_in        (go_c[i]),
      .tok_in       (tok_c[i]),
      .found_idx_in (found_idx_c[i]),
      .free_idx_in  (free_idx_c[i]),
      .best_idx_in  (best_idx_c[i]),
      .go_out       (go_c[i+1]),
      .tok_out      (tok_c[i+1]),
      .found_idx_out(found_idx_c[i+1]),
      .free_idx_out (free_idx_c[i+1]),
      .best_idx_out (best_idx_c[i+1]),
      .wr           (wr),
      .wr_idx       (wr_idx)
    );
  end

  // decide the update and the result once the token leaves the last cell
  always_comb begin
    wr         = '0;
    wr.tid     = cmd_tid;
    wr.owner   = cmd_uid;
    wr.pri     = cmd_pri;
    wr_idx     = found_idx_c[SLOTS];
    res_status = ST_OK;
    res_owner  = '0;
    unique case (cmd_mode)
      MODE_ADD: begin
        wr.keyw = 1'b1;
        if (fin.found) begin
          wr.en = finish;
        end else if (fin.free_ok) begin
          wr.en  = finish;
          wr_idx = free_idx_c[SLOTS];
        end else begin
          res_status = ST_FULL;
        end
      end
      MODE_CHG: begin
        if (fin.found) begin
          wr.en = finish;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      MODE_REM: begin
        wr.clr = 1'b1;
        if (fin.found) begin
          wr.en = finish;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      MODE_EXEC: begin
        wr.clr = 1'b1;
        wr_idx = best_idx_c[SLOTS];
        if (fin.best_ok) begin
          wr.en     = finish;
          res_owner = fin.best_owner;
        end else begin
          res_status = ST_EMPTY;
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_RUN;
      S_RUN:  if (finish) state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      inject <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      inject <= accept;
      done   <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_mode <= mode;
      cmd_tid  <= task_id;
      cmd_uid  <= user_id;
      cmd_pri  <= priority_req;
    end
    if (finish) begin
      owner  <= res_owner;
      status <= res_status;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the indexed max-priority task queue
`timescale 1ns / 1ps

module testbench import ipq_pkg::*;;

  localparam int SLOTS = 64;
  localparam int RANDOM_ITEMS = 650;
  localparam int POOL = 96;
  localparam int LIMIT = 600000;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [TID_W-1:0]  tid;
    logic [UID_W-1:0]  uid;
    logic [PRI_W-1:0]  pri;
  } command_t;

  typedef struct {
    logic [UID_W-1:0] owner;
    logic [ST_W-1:0]  status;
  } outcome_t;

  // mirror of the task table plus the outcomes still owed by the block
  class task_table_tracker;
    bit               valid[SLOTS];
    logic [TID_W-1:0] tid_of[SLOTS];
    logic [UID_W-1:0] owner_of[SLOTS];
    logic [PRI_W-1:0] pri_of[SLOTS];
    outcome_t         owed[$];
    int               errors;

    function int slot_of(logic [TID_W-1:0] t);
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && tid_of[i] == t) return i;
      return -1;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += valid[i];
      return n;
    endfunction

    function logic [TID_W-1:0] random_present_id();
      int k;
      k = $urandom_range(0, occupancy() - 1);
      for (int i = 0; i < SLOTS; i++) begin
        if (valid[i]) begin
          if (k == 0) return tid_of[i];
          k--;
        end
      end
      return '0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // apply one accepted transaction and queue the outcome it must produce
    function void note_command(command_t c);
      outcome_t r;
      int       s;
      r.owner = '0;
      r.status = ST_OK;
      s = slot_of(c.tid);
      case (c.mode)
        MODE_ADD: begin
          if (s < 0)
            for (int i = 0; i < SLOTS && s < 0; i++)
              if (!valid[i]) s = i;
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            valid[s] = 1'b1;
            tid_of[s] = c.tid;
            owner_of[s] = c.uid;
            pri_of[s] = c.pri;
          end
        end
        MODE_CHG: begin
          if (s < 0) r.status = ST_NOT_FOUND;
          else pri_of[s] = c.pri;
        end
        MODE_REM: begin
          if (s < 0) r.status = ST_NOT_FOUND;
          else valid[s] = 1'b0;
        end
        default: begin
          // highest priority wins, ties go to the larger task id
          s = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (valid[i] && (s < 0 || pri_of[i] > pri_of[s] ||
                (pri_of[i] == pri_of[s] && tid_of[i] > tid_of[s])))
              s = i;
          end
          if (s < 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.owner = owner_of[s];
            valid[s] = 1'b0;
          end
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(logic [UID_W-1:0] got_owner, logic [ST_W-1:0] got_status);
      outcome_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, owner %0h status %0d", $time, got_owner,
                 got_status);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got_status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status,
                 got_status);
        errors++;
      end
      if (got_owner !== want.owner) begin
        $display("%0t: owner mismatch, expected %0h, actual %0h", $time, want.owner,
                 got_owner);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [MODE_W-1:0] mode;
  logic [TID_W-1:0]  task_id;
  logic [UID_W-1:0]  user_id;
  logic [PRI_W-1:0]  priority_req;
  logic              done;
  logic [UID_W-1:0]  owner;
  logic [ST_W-1:0]   status;

  task_table_tracker ledger = new();
  logic [TID_W-1:0]  id_pool[POOL];
  bit                steady;
  int                sent;
  int                cycles;

  indexed_max_priority_task_queue_top #(.SLOTS(SLOTS)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .task_id      (task_id),
    .user_id      (user_id),
    .priority_req (priority_req),
    .done         (done),
    .owner        (owner),
    .status       (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) ledger.check_result(owner, status);
  end

  // mostly back to back, sometimes short pauses, now and then longer than a command
  function int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 90);
  endfunction

  function logic [PRI_W-1:0] pick_pri();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 7);
    if (r < 60) return (r < 55) ? '0 : '1;
    return $urandom;
  endfunction

  function logic [TID_W-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return TID_W'($urandom);
    return id_pool[$urandom_range(0, POOL - 1)];
  endfunction

  function logic [TID_W-1:0] fresh_id();
    logic [TID_W-1:0] t;
    for (int k = 0; k < 8; k++) begin
      t = id_pool[$urandom_range(0, POOL - 1)];
      if (ledger.slot_of(t) < 0) return t;
    end
    return TID_W'($urandom);
  endfunction

  // target a live task most of the time so edits and removals land
  function logic [TID_W-1:0] edit_id();
    if (ledger.occupancy() > 0 && $urandom_range(0, 3) != 0)
      return ledger.random_present_id();
    return pick_id();
  endfunction

  task automatic issue(input logic [MODE_W-1:0] m, input logic [TID_W-1:0] t,
                       input logic [UID_W-1:0] u, input logic [PRI_W-1:0] p);
    command_t c;
    int       gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    mode <= m;
    task_id <= t;
    user_id <= u;
    priority_req <= p;
    do @(posedge clk); while (busy);
    c.mode = m;
    c.tid = t;
    c.uid = u;
    c.pri = p;
    ledger.note_command(c);
    sent++;
  endtask

  initial begin
    int phase;
    int r;
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_ADD;
    task_id = '0;
    user_id = '0;
    priority_req = '0;
    for (int i = 0; i < POOL; i++) id_pool[i] = TID_W'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, absent ids, field extremes, overwrite, ties
    steady = 1'b0;
    issue(MODE_EXEC, TID_W'($urandom), UID_W'($urandom), $urandom);
    issue(MODE_CHG, 16'd5, UID_W'($urandom), 32'd9);
    issue(MODE_REM, 16'd5, UID_W'($urandom), $urandom);
    issue(MODE_ADD, 16'h0000, 16'h0000, 32'h0000_0000);
    issue(MODE_ADD, 16'hffff, 16'hffff, 32'hffff_ffff);
    issue(MODE_ADD, 16'h1234, 16'h0aaa, 32'hffff_ffff);
    issue(MODE_ADD, 16'h0000, 16'h5555, 32'd7);
    issue(MODE_CHG, 16'h1234, UID_W'($urandom), 32'd0);
    issue(MODE_ADD, 16'd77, 16'ha5a5, 32'd7);
    issue(MODE_EXEC, TID_W'($urandom), UID_W'($urandom), $urandom);
    issue(MODE_EXEC, TID_W'($urandom), UID_W'($urandom), $urandom);
    issue(MODE_EXEC, TID_W'($urandom), UID_W'($urandom), $urandom);
    issue(MODE_REM, 16'h1234, UID_W'($urandom), $urandom);
    issue(MODE_REM, 16'h1234, UID_W'($urandom), $urandom);
    issue(MODE_EXEC, TID_W'($urandom), UID_W'($urandom), $urandom);
    issue(MODE_ADD, 16'd3, 16'd1, 32'd10);
    issue(MODE_CHG, 16'd3, UID_W'($urandom), 32'hffff_ffff);
    issue(MODE_EXEC, TID_W'($urandom), UID_W'($urandom), $urandom);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = $urandom_range(0, 3);
      steady = ($urandom_range(0, 3) == 0);
      case (phase)
        0: begin
          // fill to capacity, then push adds against the full table
          while (ledger.occupancy() < SLOTS)
            issue(MODE_ADD, fresh_id(), UID_W'($urandom), pick_pri());
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) != 0)
              issue(MODE_ADD, ledger.random_present_id(), UID_W'($urandom), pick_pri());
            else
              issue(MODE_ADD, fresh_id(), UID_W'($urandom), pick_pri());
          end
        end
        1: begin
          // drain in priority order, with some reprioritizing along the way
          while (ledger.occupancy() > 0) begin
            if ($urandom_range(0, 4) == 0)
              issue(MODE_CHG, ledger.random_present_id(), UID_W'($urandom), pick_pri());
            else
              issue(MODE_EXEC, TID_W'($urandom), UID_W'($urandom), $urandom);
          end
          repeat ($urandom_range(1, 2))
            issue(MODE_EXEC, TID_W'($urandom), UID_W'($urandom), $urandom);
        end
        2: begin
          repeat (40) begin
            r = $urandom_range(0, 99);
            if (r < 35) issue(MODE_ADD, pick_id(), UID_W'($urandom), pick_pri());
            else if (r < 55) issue(MODE_CHG, edit_id(), UID_W'($urandom), pick_pri());
            else if (r < 75) issue(MODE_REM, edit_id(), UID_W'($urandom), $urandom);
            else issue(MODE_EXEC, TID_W'($urandom), UID_W'($urandom), $urandom);
          end
        end
        default: begin
          repeat (10)
            issue(MODE_W'($urandom), TID_W'($urandom), UID_W'($urandom), $urandom);
        end
      endcase
    end

    @(negedge clk);
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
